// ===== design/mhpq_pkg.sv =====
package mhpq_pkg;

	localparam int HEAP_CAPACITY = 64;
	localparam int IDX_W = $clog2(HEAP_CAPACITY);
	localparam int CNT_W = $clog2(HEAP_CAPACITY + 1);
	// Child positions of the deepest node reach 2 * capacity, so they get two more bits.
	localparam int CHILD_W = IDX_W + 2;
	localparam int KEY_W = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CHILD_W-1:0] child_t;
	typedef logic signed [KEY_W-1:0] key_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_EX_TOP,
		S_EX_LAST,
		S_DN_L,
		S_DN_R,
		S_PUT
	} state_t;

	function automatic idx_t parent_of(input idx_t pos);
		parent_of = (pos - idx_t'(1)) >> 1;
	endfunction

	function automatic child_t left_of(input idx_t pos);
		left_of = {1'b0, pos, 1'b1};
	endfunction

endpackage

// ===== design/mhpq_store.sv =====
module mhpq_store (
	input  logic           clk,
	input  logic           we,
	input  mhpq_pkg::idx_t waddr,
	input  mhpq_pkg::key_t wdata,
	input  mhpq_pkg::idx_t raddr,
	output mhpq_pkg::key_t rdata
);
	import mhpq_pkg::*;

	key_t mem [HEAP_CAPACITY];
	key_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/max_heap_priority_queue.sv =====
// Binary max-heap priority queue of signed 32-bit keys, capacity 64.
// Command channel: an item transfers on a rising edge with start high and busy low.
// operation 0 inserts key_in; operation 1 removes the maximum and returns it.
// Result channel: done is high for exactly one cycle with key_out, status and
// occupancy; the receiver takes it in that cycle and cannot hold it off.
// status 1 means the insert was dropped because the heap is full, status 2 an
// extract from an empty heap; key_out is zero except on a good extract.
// A rejected item reports in the cycle after its transfer. An insert takes one
// S_UP step per level climbed, an extract an S_DN_L and, if a right child
// exists, an S_DN_R step per level descended. The heap sits in a single
// one-read one-write store with registered read data, and one signed comparator
// serves every step of the sift, so each level costs one store read per key.
// busy is high while an item is being sifted; a new item may transfer in the
// cycle done is shown. Reset empties the heap at once; the store is not cleared.
module max_heap_priority_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  operation,
	input  logic signed [31:0]    key_in,
	output logic                  done,
	output logic signed [31:0]    key_out,
	output logic [1:0]            status,
	output logic [mhpq_pkg::CNT_W-1:0] occupancy
);
	import mhpq_pkg::*;

	state_t state_q, state_d;
	cnt_t   count_q, count_d;
	idx_t   pos_q, pos_d;
	key_t   cur_q, cur_d;
	key_t   top_q, top_d;
	key_t   pick_val_q, pick_val_d;
	logic   pick_l_q, pick_l_d;
	logic   op_q, op_d;

	logic       done_q, done_d;
	key_t       key_out_q, key_out_d;
	logic [1:0] status_q, status_d;

	logic   we;
	idx_t   waddr, raddr;
	key_t   wdata, rdata;

	key_t   cmp_a, cmp_b;
	logic   ge;
	child_t lchild, rchild, next_l;
	idx_t   par, pick;

	mhpq_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// The one shared comparator of the sift.
	assign ge = cmp_a >= cmp_b;

	assign par    = parent_of(pos_q);
	assign lchild = left_of(pos_q);
	assign rchild = lchild + child_t'(1);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		pos_d      = pos_q;
		cur_d      = cur_q;
		top_d      = top_q;
		pick_val_d = pick_val_q;
		pick_l_d   = pick_l_q;
		op_d       = op_q;
		done_d     = 1'b0;
		key_out_d  = key_out_q;
		status_d   = status_q;
		we         = 1'b0;
		waddr      = pos_q;
		wdata      = cur_q;
		raddr      = '0;
		cmp_a      = cur_q;
		cmp_b      = rdata;
		pick       = pos_q;
		next_l     = '0;

		unique case (state_q)
			S_IDLE: begin
				raddr = (operation == OP_INSERT) ?
					idx_t'((count_q - cnt_t'(1)) >> 1) : '0;
				if (start) begin
					op_d  = operation;
					cur_d = key_in;
					pos_d = idx_t'(count_q);
					if (operation == OP_INSERT) begin
						if (count_q == cnt_t'(HEAP_CAPACITY)) begin
							done_d    = 1'b1;
							key_out_d = '0;
							status_d  = STATUS_FULL;
						end else begin
							count_d = count_q + cnt_t'(1);
							state_d = (count_q == '0) ? S_PUT : S_UP;
						end
					end else begin
						if (count_q == '0) begin
							done_d    = 1'b1;
							key_out_d = '0;
							status_d  = STATUS_EMPTY;
						end else begin
							count_d = count_q - cnt_t'(1);
							state_d = S_EX_TOP;
						end
					end
				end
			end
			S_UP: begin
				// rdata holds the parent; the new key climbs while it is not smaller.
				cmp_a = cur_q;
				cmp_b = rdata;
				raddr = parent_of(par);
				we    = 1'b1;
				if (ge) begin
					wdata = rdata;
					pos_d = par;
					if (par == '0) begin
						state_d = S_PUT;
					end
				end else begin
					wdata     = cur_q;
					done_d    = 1'b1;
					key_out_d = '0;
					status_d  = STATUS_DONE;
					state_d   = S_IDLE;
				end
			end
			S_EX_TOP: begin
				top_d   = rdata;
				raddr   = idx_t'(count_q);
				state_d = S_EX_LAST;
			end
			S_EX_LAST: begin
				cur_d = rdata;
				pos_d = '0;
				raddr = idx_t'(1 % HEAP_CAPACITY);
				if (count_q == '0) begin
					done_d    = 1'b1;
					key_out_d = top_q;
					status_d  = STATUS_DONE;
					state_d   = S_IDLE;
				end else if (count_q == cnt_t'(1)) begin
					state_d = S_PUT;
				end else begin
					state_d = S_DN_L;
				end
			end
			S_DN_L: begin
				// rdata holds the left child.
				cmp_a      = rdata;
				cmp_b      = cur_q;
				pick_l_d   = ge;
				pick_val_d = ge ? rdata : cur_q;
				raddr      = rchild[IDX_W-1:0];
				if (rchild < child_t'(count_q)) begin
					state_d = S_DN_R;
				end else if (ge) begin
					// The left child is a leaf once the right one is out of range.
					we      = 1'b1;
					wdata   = rdata;
					pos_d   = lchild[IDX_W-1:0];
					state_d = S_PUT;
				end else begin
					state_d = S_PUT;
				end
			end
			S_DN_R: begin
				cmp_a = rdata;
				cmp_b = pick_val_q;
				if (ge || pick_l_q) begin
					pick   = ge ? rchild[IDX_W-1:0] : lchild[IDX_W-1:0];
					next_l = left_of(pick);
					we     = 1'b1;
					wdata  = ge ? rdata : pick_val_q;
					pos_d  = pick;
					raddr  = next_l[IDX_W-1:0];
					state_d = (next_l < child_t'(count_q)) ? S_DN_L : S_PUT;
				end else begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				we        = 1'b1;
				waddr     = pos_q;
				wdata     = cur_q;
				done_d    = 1'b1;
				key_out_d = (op_q == OP_EXTRACT) ? top_q : '0;
				status_d  = STATUS_DONE;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q      <= pos_d;
		cur_q      <= cur_d;
		top_q      <= top_d;
		pick_val_q <= pick_val_d;
		pick_l_q   <= pick_l_d;
		op_q       <= op_d;
		key_out_q  <= key_out_d;
		status_q   <= status_d;
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign key_out   = key_out_q;
	assign status    = status_q;
	assign occupancy = count_q;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import mhpq_pkg::*;

	typedef struct {
		logic op;
		key_t key;
	} heap_cmd_t;

	typedef struct {
		key_t key;
		logic [1:0] status;
		cnt_t count;
	} heap_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic operation = OP_INSERT;
	key_t key_in = '0;
	logic busy;
	logic done;
	key_t key_out;
	logic [1:0] status;
	cnt_t occupancy;

	heap_cmd_t cmd_queue[$];
	heap_result_t expected_results[$];
	key_t heap_keys[HEAP_CAPACITY];
	int heap_size = 0;
	int mismatches = 0;
	int burst_left = 0;
	int gap_left = 0;

	max_heap_priority_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.key_in(key_in),
		.done(done),
		.key_out(key_out),
		.status(status),
		.occupancy(occupancy)
	);

	always #5 clk = ~clk;

	// Applies one command to the shadow heap and returns the result it should report.
	function automatic heap_result_t heap_step(input logic op, input key_t key);
		heap_result_t r;
		int pos;
		int parent;
		int left;
		int right;
		int pick;
		key_t held;
		r.key = '0;
		r.status = STATUS_DONE;
		if (op == OP_INSERT) begin
			if (heap_size >= HEAP_CAPACITY) begin
				r.status = STATUS_FULL;
			end else begin
				heap_keys[heap_size] = key;
				pos = heap_size;
				heap_size++;
				while (pos > 0) begin
					parent = (pos - 1) / 2;
					if (heap_keys[pos] < heap_keys[parent])
						break;
					held = heap_keys[pos];
					heap_keys[pos] = heap_keys[parent];
					heap_keys[parent] = held;
					pos = parent;
				end
			end
		end else begin
			if (heap_size == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				r.key = heap_keys[0];
				heap_size--;
				heap_keys[0] = heap_keys[heap_size];
				pos = 0;
				while (pos < heap_size) begin
					left = 2 * pos + 1;
					right = 2 * pos + 2;
					pick = pos;
					// Ties go to the child, and the right child wins a tie with the left.
					if (left < heap_size && heap_keys[left] >= heap_keys[pick])
						pick = left;
					if (right < heap_size && heap_keys[right] >= heap_keys[pick])
						pick = right;
					if (pick == pos)
						break;
					held = heap_keys[pos];
					heap_keys[pos] = heap_keys[pick];
					heap_keys[pick] = held;
					pos = pick;
				end
			end
		end
		r.count = cnt_t'(heap_size);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic queue_cmd(input logic op, input key_t key);
		heap_cmd_t c;
		c.op = op;
		c.key = key;
		cmd_queue.insert(cmd_queue.size(), c);
	endtask

	// Command driver: holds start until the transfer, then idles in random gaps between bursts.
	always @(posedge clk) begin : driver
		heap_cmd_t c;
		if (arst_n) begin
			if (start && !busy)
				expected_results.insert(expected_results.size(),
					heap_step(operation, key_in));
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					c = cmd_queue.pop_front();
					start <= 1'b1;
					operation <= c.op;
					key_in <= c.key;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 30);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		heap_result_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result key %0d status %0d count %0d",
					key_out, status, occupancy));
			end else begin
				exp_r = expected_results.pop_front();
				if (key_out !== exp_r.key)
					report_mismatch($sformatf("key_out %0d, want %0d", key_out, exp_r.key));
				if (status !== exp_r.status)
					report_mismatch($sformatf("status %0d, want %0d", status, exp_r.status));
				if (occupancy !== exp_r.count)
					report_mismatch($sformatf("occupancy %0d, want %0d",
						occupancy, exp_r.count));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int phase_len;
		int insert_weight;
		int total;
		key_t key;
		logic op;

		// Directed: empty extract, extreme keys, duplicates, drain to empty and past it.
		queue_cmd(OP_EXTRACT, '0);
		queue_cmd(OP_INSERT, 32'sh7FFF_FFFF);
		queue_cmd(OP_INSERT, 32'sh8000_0000);
		queue_cmd(OP_INSERT, 32'sd0);
		queue_cmd(OP_INSERT, -32'sd1);
		queue_cmd(OP_INSERT, 32'sd1);
		queue_cmd(OP_INSERT, 32'sd5);
		queue_cmd(OP_INSERT, 32'sd5);
		queue_cmd(OP_INSERT, -32'sd1);
		repeat (4) queue_cmd(OP_EXTRACT, 32'sh1234_5678);
		queue_cmd(OP_INSERT, 32'sh5555_5555);
		queue_cmd(OP_INSERT, 32'shAAAA_AAAA);
		repeat (7) queue_cmd(OP_EXTRACT, '1);

		// Random phases lean toward filling, draining or mixing so that the full
		// and empty corners are reached repeatedly.
		total = 0;
		phase = 0;
		while (total < 528) begin
			phase_len = $urandom_range(60, 110);
			if (phase_len > 528 - total)
				phase_len = 528 - total;
			case (phase % 3)
				0: insert_weight = 7;
				1: insert_weight = 4;
				default: insert_weight = 1;
			endcase
			repeat (phase_len) begin
				op = ($urandom_range(0, 7) < insert_weight) ? OP_INSERT : OP_EXTRACT;
				case ($urandom_range(0, 5))
					0: key = key_t'($urandom_range(0, 15)) - 32'sd8;
					1: begin
						case ($urandom_range(0, 3))
							0: key = 32'sh7FFF_FFFF;
							1: key = 32'sh8000_0000;
							2: key = 32'sd0;
							default: key = -32'sd1;
						endcase
					end
					default: key = key_t'($urandom);
				endcase
				queue_cmd(op, key);
			end
			total += phase_len;
			phase++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() > 0 || start || expected_results.size() > 0)
			@(negedge clk);
		repeat (40) @(negedge clk);

		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
